@@ rtl/kmm_agg_pkg.sv @@
package kmm_agg_pkg;

    localparam int SLOTS     = 16384;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int KEY_BYTES = 63;
    localparam int KLEN_W    = $clog2(KEY_BYTES + 1);
    localparam int CHUNKS    = 8;
    localparam int CHUNK_W   = 3;
    localparam int NLEN_W    = 6;
    localparam int COUNT_W   = 40;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [32:0]        MAG_LIMIT = 33'h0_8000_0000;

    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MIN  = 8'h2D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    typedef enum logic {
        OP_FEED = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic {
        PH_KEY   = 1'b0,
        PH_VALUE = 1'b1
    } line_phase_t;

    typedef enum logic [1:0] {
        NUM_BEFORE = 2'd0,
        NUM_DIGITS = 2'd1,
        NUM_DONE   = 2'd2
    } num_phase_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE_INIT,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_INSERT,
        ST_UPDATE,
        ST_RD_NAME,
        ST_RD_OUT
    } state_t;

    typedef struct packed {
        logic        operation;
        logic [7:0]  data_byte;
        logic        final_byte;
        logic [13:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [2:0]          chunk_index;
        logic [63:0]         name_chunk;
        logic [5:0]          name_length;
        logic                slot_used;
        logic signed [31:0]  min_value;
        logic signed [31:0]  max_value;
        logic signed [63:0]  total_sum;
        logic [39:0]         sample_count;
        logic                table_full;
        logic                last;
    } rsp_t;

    typedef struct packed {
        logic                used;
        logic [NLEN_W-1:0]   name_len;
        logic signed [31:0]  min_v;
        logic signed [31:0]  max_v;
        logic signed [63:0]  sum;
        logic [COUNT_W-1:0]  count;
    } stat_t;

    typedef struct packed {
        logic                rec;
        logic [KLEN_W-1:0]   len;
        logic [SLOT_W-1:0]   hash;
        logic signed [31:0]  value;
    } line_t;

    typedef logic [CHUNKS-1:0][7:0][7:0] key_t;

endpackage

@@ rtl/kmm_agg_parse.sv @@
module kmm_agg_parse (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      feed,
    input  logic [7:0]                data_byte,
    input  logic                      final_byte,
    input  logic                      clear,
    output kmm_agg_pkg::line_t        line,
    output kmm_agg_pkg::key_t         key
);

    kmm_agg_pkg::key_t                   key_reg, key_next;
    logic [kmm_agg_pkg::KLEN_W-1:0]      len_reg, len_next;
    logic [kmm_agg_pkg::SLOT_W-1:0]      hash_reg, hash_next;
    kmm_agg_pkg::line_phase_t            phase_reg, phase_next;
    kmm_agg_pkg::num_phase_t             nph_reg, nph_next;
    logic                                neg_reg, neg_next;
    logic [31:0]                         acc_reg, acc_next;
    logic                                finish;
    logic                                is_digit;
    logic                                is_blank;
    logic [32:0]                         acc_add;
    logic [kmm_agg_pkg::SLOT_W+7:0]      hash_mix;

    assign is_digit = (data_byte >= kmm_agg_pkg::CH_0) && (data_byte <= kmm_agg_pkg::CH_9);
    assign is_blank = (data_byte == kmm_agg_pkg::CH_SP) || (data_byte == kmm_agg_pkg::CH_TAB)
                   || (data_byte == kmm_agg_pkg::CH_VT) || (data_byte == kmm_agg_pkg::CH_FF)
                   || (data_byte == kmm_agg_pkg::CH_CR);

    // acc*10 + digit, saturated at 2^31
    always_comb
    begin
        logic [35:0] prod;
        prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
             + {32'd0, data_byte[3:0] - kmm_agg_pkg::CH_0[3:0]};
        if (prod > {3'b000, kmm_agg_pkg::MAG_LIMIT})
            acc_add = kmm_agg_pkg::MAG_LIMIT;
        else
            acc_add = prod[32:0];
    end

    // h*31 + c, kept to the slot range
    assign hash_mix = ({8'd0, hash_reg} << 5) - {8'd0, hash_reg}
                    + {{kmm_agg_pkg::SLOT_W{1'b0}}, data_byte};

    always_comb
    begin
        key_next   = key_reg;
        len_next   = len_reg;
        hash_next  = hash_reg;
        phase_next = phase_reg;
        nph_next   = nph_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        finish     = 1'b0;
        if (feed)
        begin
            if (data_byte == kmm_agg_pkg::CH_LF)
            begin
                finish = 1'b1;
            end
            else
            begin
                if (phase_reg == kmm_agg_pkg::PH_KEY)
                begin
                    if (data_byte == kmm_agg_pkg::CH_SEMI)
                    begin
                        phase_next = kmm_agg_pkg::PH_VALUE;
                    end
                    else if (len_reg < kmm_agg_pkg::KLEN_W'(kmm_agg_pkg::KEY_BYTES))
                    begin
                        key_next[len_reg[kmm_agg_pkg::KLEN_W-1:3]][len_reg[2:0]] = data_byte;
                        len_next  = len_reg + 1'b1;
                        hash_next = hash_mix[kmm_agg_pkg::SLOT_W-1:0];
                    end
                end
                else if (data_byte != kmm_agg_pkg::CH_DOT)
                begin
                    unique case (nph_reg)
                        kmm_agg_pkg::NUM_BEFORE:
                        begin
                            if (is_blank)
                            begin
                                nph_next = kmm_agg_pkg::NUM_BEFORE;
                            end
                            else if (data_byte == kmm_agg_pkg::CH_PLUS)
                            begin
                                nph_next = kmm_agg_pkg::NUM_DIGITS;
                            end
                            else if (data_byte == kmm_agg_pkg::CH_MIN)
                            begin
                                neg_next = 1'b1;
                                nph_next = kmm_agg_pkg::NUM_DIGITS;
                            end
                            else if (is_digit)
                            begin
                                acc_next = acc_add[31:0];
                                nph_next = kmm_agg_pkg::NUM_DIGITS;
                            end
                            else
                            begin
                                nph_next = kmm_agg_pkg::NUM_DONE;
                            end
                        end
                        kmm_agg_pkg::NUM_DIGITS:
                        begin
                            if (is_digit)
                                acc_next = acc_add[31:0];
                            else
                                nph_next = kmm_agg_pkg::NUM_DONE;
                        end
                        default:
                        begin
                            nph_next = nph_reg;
                        end
                    endcase
                end
                if (final_byte)
                    finish = 1'b1;
            end
        end
        // a line without ';' is dropped at once; a stored one waits for clear
        if ((finish && (phase_next == kmm_agg_pkg::PH_KEY)) || clear)
        begin
            key_next   = '0;
            len_next   = '0;
            hash_next  = '0;
            phase_next = kmm_agg_pkg::PH_KEY;
            nph_next   = kmm_agg_pkg::NUM_BEFORE;
            neg_next   = 1'b0;
            acc_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            len_reg   <= '0;
            hash_reg  <= '0;
            phase_reg <= kmm_agg_pkg::PH_KEY;
            nph_reg   <= kmm_agg_pkg::NUM_BEFORE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            key_reg   <= key_next;
            len_reg   <= len_next;
            hash_reg  <= hash_next;
            phase_reg <= phase_next;
            nph_reg   <= nph_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

    assign line.rec  = finish && (phase_next == kmm_agg_pkg::PH_VALUE);
    assign line.len  = len_reg;
    assign line.hash = hash_reg;

    always_comb
    begin
        if (neg_reg)
            line.value = $signed(~acc_reg + 32'd1);
        else if (acc_reg[31])
            line.value = 32'sh7FFF_FFFF;
        else
            line.value = $signed(acc_reg);
    end

    assign key = key_reg;

endmodule

@@ rtl/keyed_min_max_sum_aggregator_top.sv @@
// Channel   | Handshake            | Beat
// ----------+----------------------+--------------------------------------
// req       | req_valid/req_stall  | one text byte or one slot read
// rsp       | rsp_valid/rsp_stall  | one name chunk plus slot statistics
//
// A text byte is taken whenever req is not stalled. The end of a stored line
// runs the probe: a start step, a read and check of each slot visited plus a
// read and compare of each name chunk, then an insert that writes every name
// chunk or an update. A slot read gives 8 beats.
// After reset a clearing pass over all SLOTS (16384) slots marks every slot
// free; req is stalled meanwhile. req is stalled while a probe or read is
// busy; a waiting rsp beat does not stall req once the read has finished.
module keyed_min_max_sum_aggregator_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  kmm_agg_pkg::req_t    req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output kmm_agg_pkg::rsp_t    rsp_data
);

    localparam int NADDR_W = kmm_agg_pkg::SLOT_W + kmm_agg_pkg::CHUNK_W;

    kmm_agg_pkg::state_t             state_reg, state_next;
    logic [kmm_agg_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [kmm_agg_pkg::SLOT_W:0]    tries_reg, tries_next;
    logic [kmm_agg_pkg::CHUNK_W-1:0] chunk_reg, chunk_next;
    logic                            full_reg, full_next;
    logic                            ovalid_reg, ovalid_next;
    kmm_agg_pkg::rsp_t               out_reg, out_next;

    // slot statistics (with used bit) and slot names, registered reads
    kmm_agg_pkg::stat_t              stat_mem [kmm_agg_pkg::SLOTS];
    logic [63:0]                     name_mem [kmm_agg_pkg::SLOTS * kmm_agg_pkg::CHUNKS];
    kmm_agg_pkg::stat_t              stat_rd_reg;
    logic [63:0]                     name_rd_reg;

    logic                            stat_re, stat_we, name_re, name_we;
    logic [kmm_agg_pkg::SLOT_W-1:0]  stat_addr;
    kmm_agg_pkg::stat_t              stat_wdata;
    logic [NADDR_W-1:0]              name_addr;

    logic                            accept, feed, line_clear;
    logic [kmm_agg_pkg::SLOT_W-1:0]  req_slot;
    kmm_agg_pkg::line_t              line;
    kmm_agg_pkg::key_t               key;
    logic [kmm_agg_pkg::CHUNK_W-1:0] last_chunk;
    logic signed [31:0]              v;

    assign req_stall = (state_reg != kmm_agg_pkg::ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign feed      = accept && (req_data.operation == kmm_agg_pkg::OP_FEED);
    assign req_slot  = kmm_agg_pkg::SLOT_W'(req_data.slot_index);
    assign name_addr = {slot_reg, chunk_reg};
    assign v         = line.value;
    assign last_chunk = kmm_agg_pkg::CHUNK_W'((6'(line.len) - 6'd1) >> 3);

    kmm_agg_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed       (feed),
        .data_byte  (req_data.data_byte),
        .final_byte (req_data.final_byte),
        .clear      (line_clear),
        .line       (line),
        .key        (key)
    );

    always_ff @(posedge clk)
    begin
        if (stat_we)
            stat_mem[stat_addr] <= stat_wdata;
        if (stat_re)
            stat_rd_reg <= stat_mem[stat_addr];
    end

    always_ff @(posedge clk)
    begin
        if (name_we)
            name_mem[name_addr] <= key[chunk_reg];
        if (name_re)
            name_rd_reg <= name_mem[name_addr];
    end

    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        tries_next  = tries_reg;
        chunk_next  = chunk_reg;
        full_next   = full_reg;
        ovalid_next = ovalid_reg && rsp_stall;
        out_next    = out_reg;
        stat_re     = 1'b0;
        stat_we     = 1'b0;
        name_re     = 1'b0;
        name_we     = 1'b0;
        stat_addr   = slot_reg;
        stat_wdata  = '0;
        line_clear  = 1'b0;

        unique case (state_reg)
            kmm_agg_pkg::ST_CLEAR:
            begin
                stat_we   = 1'b1;
                slot_next = slot_reg + 1'b1;
                if (slot_reg == kmm_agg_pkg::SLOT_W'(kmm_agg_pkg::SLOTS - 1))
                    state_next = kmm_agg_pkg::ST_IDLE;
            end
            kmm_agg_pkg::ST_IDLE:
            begin
                if (accept && (req_data.operation == kmm_agg_pkg::OP_READ))
                begin
                    stat_re    = 1'b1;
                    stat_addr  = req_slot;
                    slot_next  = req_slot;
                    chunk_next = '0;
                    state_next = kmm_agg_pkg::ST_RD_NAME;
                end
                else if (line.rec)
                begin
                    state_next = kmm_agg_pkg::ST_PROBE_INIT;
                end
            end
            kmm_agg_pkg::ST_PROBE_INIT:
            begin
                slot_next  = line.hash;
                tries_next = '0;
                state_next = kmm_agg_pkg::ST_PROBE_RD;
            end
            kmm_agg_pkg::ST_PROBE_RD:
            begin
                if (tries_reg == (kmm_agg_pkg::SLOT_W + 1)'(kmm_agg_pkg::SLOTS))
                begin
                    full_next  = 1'b1;
                    line_clear = 1'b1;
                    state_next = kmm_agg_pkg::ST_IDLE;
                end
                else
                begin
                    stat_re    = 1'b1;
                    state_next = kmm_agg_pkg::ST_PROBE_CHK;
                end
            end
            kmm_agg_pkg::ST_PROBE_CHK:
            begin
                chunk_next = '0;
                if (!stat_rd_reg.used)
                    state_next = kmm_agg_pkg::ST_INSERT;
                else if (stat_rd_reg.name_len == 6'(line.len))
                    state_next = (line.len == '0) ? kmm_agg_pkg::ST_UPDATE
                                                  : kmm_agg_pkg::ST_CMP_RD;
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    tries_next = tries_reg + 1'b1;
                    state_next = kmm_agg_pkg::ST_PROBE_RD;
                end
            end
            kmm_agg_pkg::ST_CMP_RD:
            begin
                name_re    = 1'b1;
                state_next = kmm_agg_pkg::ST_CMP_CHK;
            end
            kmm_agg_pkg::ST_CMP_CHK:
            begin
                if (name_rd_reg != key[chunk_reg])
                begin
                    slot_next  = slot_reg + 1'b1;
                    tries_next = tries_reg + 1'b1;
                    state_next = kmm_agg_pkg::ST_PROBE_RD;
                end
                else if (chunk_reg == last_chunk)
                begin
                    state_next = kmm_agg_pkg::ST_UPDATE;
                end
                else
                begin
                    chunk_next = chunk_reg + 1'b1;
                    state_next = kmm_agg_pkg::ST_CMP_RD;
                end
            end
            kmm_agg_pkg::ST_INSERT:
            begin
                name_we    = 1'b1;
                chunk_next = chunk_reg + 1'b1;
                if (chunk_reg == kmm_agg_pkg::CHUNK_W'(kmm_agg_pkg::CHUNKS - 1))
                begin
                    stat_we             = 1'b1;
                    stat_wdata.used     = 1'b1;
                    stat_wdata.name_len = 6'(line.len);
                    stat_wdata.min_v    = v;
                    stat_wdata.max_v    = v;
                    stat_wdata.sum      = {{32{v[31]}}, v};
                    stat_wdata.count    = kmm_agg_pkg::COUNT_W'(1);
                    line_clear          = 1'b1;
                    state_next          = kmm_agg_pkg::ST_IDLE;
                end
            end
            kmm_agg_pkg::ST_UPDATE:
            begin
                stat_we          = 1'b1;
                stat_wdata       = stat_rd_reg;
                stat_wdata.min_v = (v < stat_rd_reg.min_v) ? v : stat_rd_reg.min_v;
                stat_wdata.max_v = (v > stat_rd_reg.max_v) ? v : stat_rd_reg.max_v;
                stat_wdata.sum   = stat_rd_reg.sum + {{32{v[31]}}, v};
                if (stat_rd_reg.count != kmm_agg_pkg::COUNT_MAX)
                    stat_wdata.count = stat_rd_reg.count + 1'b1;
                line_clear       = 1'b1;
                state_next       = kmm_agg_pkg::ST_IDLE;
            end
            kmm_agg_pkg::ST_RD_NAME:
            begin
                name_re    = 1'b1;
                state_next = kmm_agg_pkg::ST_RD_OUT;
            end
            kmm_agg_pkg::ST_RD_OUT:
            begin
                if (!ovalid_reg || !rsp_stall)
                begin
                    ovalid_next           = 1'b1;
                    out_next.chunk_index  = chunk_reg;
                    out_next.slot_used    = stat_rd_reg.used;
                    out_next.table_full   = full_reg;
                    out_next.last         = (chunk_reg ==
                                             kmm_agg_pkg::CHUNK_W'(kmm_agg_pkg::CHUNKS - 1));
                    if (stat_rd_reg.used)
                    begin
                        out_next.name_chunk   = name_rd_reg;
                        out_next.name_length  = stat_rd_reg.name_len;
                        out_next.min_value    = stat_rd_reg.min_v;
                        out_next.max_value    = stat_rd_reg.max_v;
                        out_next.total_sum    = stat_rd_reg.sum;
                        out_next.sample_count = stat_rd_reg.count;
                    end
                    else
                    begin
                        out_next.name_chunk   = '0;
                        out_next.name_length  = '0;
                        out_next.min_value    = '0;
                        out_next.max_value    = '0;
                        out_next.total_sum    = '0;
                        out_next.sample_count = '0;
                    end
                    chunk_next = chunk_reg + 1'b1;
                    state_next = out_next.last ? kmm_agg_pkg::ST_IDLE
                                               : kmm_agg_pkg::ST_RD_NAME;
                end
            end
            default:
            begin
                state_next = kmm_agg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= kmm_agg_pkg::ST_CLEAR;
            slot_reg   <= '0;
            tries_reg  <= '0;
            chunk_reg  <= '0;
            full_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            slot_reg   <= slot_next;
            tries_reg  <= tries_next;
            chunk_reg  <= chunk_next;
            full_reg   <= full_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp_valid = ovalid_reg;
    assign rsp_data  = out_reg;

    // an update only ever lands on a slot that holds a key
    a_update_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kmm_agg_pkg::ST_UPDATE) |-> stat_rd_reg.used)
        else $error("update on a free slot");

    // a stored line always starts a probe next cycle
    a_rec_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kmm_agg_pkg::ST_IDLE && line.rec) |=>
        (state_reg == kmm_agg_pkg::ST_PROBE_INIT))
        else $error("record without probe");

    // the full flag is sticky
    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("full flag dropped");

    // no name and statistics memory write together except at insert end
    a_write_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (name_we && stat_we) |-> (chunk_reg ==
            kmm_agg_pkg::CHUNK_W'(kmm_agg_pkg::CHUNKS - 1)))
        else $error("stray statistics write");

endmodule
